// ----- rtl/core/ald_pkg.sv -----
// ----------------------------------------------------------------------------
// ald_pkg
// shared types and constants of the analog ladder button decoder
// ----------------------------------------------------------------------------
package ald_pkg;

    // fixed field widths
    localparam int LEVEL_W   = 10;
    localparam int BUTTON_W  = 4;
    localparam int SLOT_W    = 3;
    localparam int TIME_W    = 32;
    localparam int MS_W      = 16;
    localparam int WIN_W     = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    typedef logic [LEVEL_W-1:0]  t_level;
    typedef logic [BUTTON_W-1:0] t_button;
    typedef logic [SLOT_W-1:0]   t_slot;
    typedef logic [TIME_W-1:0]   t_time;
    typedef logic [MS_W-1:0]     t_ms;
    typedef logic [WIN_W-1:0]    t_win;

    // item commands
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    // event codes
    typedef enum logic [1:0] {
        EV_RELEASED = 2'd0,
        EV_PRESSED  = 2'd1,
        EV_LONG     = 2'd2,
        EV_TICK     = 2'd3
    } t_event;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ZERO_LEVEL    = 3'd0,
        REG_BUTTON_COUNT  = 3'd1,
        REG_MATCH_WINDOW  = 3'd2,
        REG_NOISE_WINDOW  = 3'd3,
        REG_LONG_PRESS_MS = 3'd4,
        REG_REPEAT_MS     = 3'd5,
        REG_SAMPLE_PERIOD = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        t_level            zero_level;
        logic [3:0]        button_count;
        t_win              match_window;
        t_win              noise_window;
        t_ms               long_press_ms;
        t_ms               repeat_ms;
        t_ms               sample_period_ms;
    } t_cfg;

    // result of the shared difference unit
    typedef struct packed {
        t_time diff;
        logic  lt;
        logic  le;
    } t_cmp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PERIOD,
        S_NOISE,
        S_ZERO,
        S_SCAN,
        S_CHANGE,
        S_REL,
        S_PRS,
        S_HOLD,
        S_HEV,
        S_FIN
    } t_state;

endpackage

// ----- rtl/core/ald_in_if.sv -----
// ----------------------------------------------------------------------------
// ald_in_if
// input channel: sample or threshold load items
// ----------------------------------------------------------------------------
interface ald_in_if;
    import ald_pkg::*;

    logic   valid;
    logic   ready;
    logic   cmd;
    t_level level;
    t_slot  slot;
    t_time  now_ms;

    modport source (output valid, cmd, level, slot, now_ms, input ready);
    modport sink   (input valid, cmd, level, slot, now_ms, output ready);
endinterface

// ----- rtl/core/ald_out_if.sv -----
// ----------------------------------------------------------------------------
// ald_out_if
// output channel: button events
// ----------------------------------------------------------------------------
interface ald_out_if;
    import ald_pkg::*;

    logic       valid;
    logic       ready;
    t_button    button;
    logic [1:0] event_res;
    t_time      duration_ms;
    logic       last;

    modport source (output valid, button, event_res, duration_ms, last, input ready);
    modport sink   (input valid, button, event_res, duration_ms, last, output ready);
endinterface

// ----- rtl/core/ald_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// ald_cfg_regs
// configuration register bank, write only
// ----------------------------------------------------------------------------
module ald_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_we,
    input  logic [ald_pkg::CFG_IDX_W-1:0]       i_idx,
    input  logic [ald_pkg::CFG_DAT_W-1:0]       i_wdata,
    output ald_pkg::t_cfg                       o_cfg
);
    import ald_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            unique case (i_idx)
                REG_ZERO_LEVEL:    n_cfg.zero_level       = i_wdata[LEVEL_W-1:0];
                REG_BUTTON_COUNT:  n_cfg.button_count     = i_wdata[3:0];
                REG_MATCH_WINDOW:  n_cfg.match_window     = i_wdata[WIN_W-1:0];
                REG_NOISE_WINDOW:  n_cfg.noise_window     = i_wdata[WIN_W-1:0];
                REG_LONG_PRESS_MS: n_cfg.long_press_ms    = i_wdata[MS_W-1:0];
                REG_REPEAT_MS:     n_cfg.repeat_ms        = i_wdata[MS_W-1:0];
                REG_SAMPLE_PERIOD: n_cfg.sample_period_ms = i_wdata[MS_W-1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;
endmodule

// ----- rtl/core/ald_diff_unit.sv -----
// ----------------------------------------------------------------------------
// ald_diff_unit
// shared subtract and compare unit, plain wrapping or absolute difference
// ----------------------------------------------------------------------------
module ald_diff_unit (
    input  logic [ald_pkg::TIME_W-1:0] i_a,
    input  logic [ald_pkg::TIME_W-1:0] i_b,
    input  logic [ald_pkg::TIME_W-1:0] i_lim,
    input  logic                       i_abs,
    output ald_pkg::t_cmp              o_cmp
);
    import ald_pkg::*;

    t_time w_fwd;
    t_time w_bwd;
    t_time w_mag;

    assign w_fwd = i_a - i_b;
    assign w_bwd = i_b - i_a;
    // absolute mode picks the non-negative direction
    assign w_mag = (i_abs && (i_a < i_b)) ? w_bwd : w_fwd;

    assign o_cmp.diff = w_mag;
    assign o_cmp.lt   = w_mag < i_lim;
    assign o_cmp.le   = w_mag <= i_lim;
endmodule

// ----- rtl/core/analog_ladder_button_decoder.sv -----
// ----------------------------------------------------------------------------
// analog_ladder_button_decoder
// resistor ladder keypad decoder with debounce, long press and repeat events
// ----------------------------------------------------------------------------
// A threshold load item (cmd 1) is taken straight from idle and gives no
// event. A sample item (cmd 0) is worked through by a small sequencer around
// one shared 32-bit subtract and compare unit, one step per cycle while no
// emit step waits on a full output register: sample period check, noise
// check, then on a stable reading a zero level check and a walk over the
// threshold table, one entry per cycle, then event generation. The walk
// covers at most MAX_BUTTONS entries, and a walk with no match ends with a
// separate end check; an early sample goes back to idle after the period
// check. The input is not ready until the item is done. Events leave
// through a one-entry output register, so up to two events per sample
// (release then press, or long press or tick) go out while the sequencer
// keeps going. Configuration writes land at once and are meant to happen
// only while the block is idle.
// ----------------------------------------------------------------------------
module analog_ladder_button_decoder #(
    parameter int MAX_BUTTONS  = 8,
    parameter int STABLE_COUNT = 3
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ald_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ald_pkg::CFG_DAT_W-1:0]       i_cfg_wdata,
    ald_in_if.sink                              i_sample,
    ald_out_if.source                           o_event
);
    import ald_pkg::*;

    localparam int         IDX_W    = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;
    localparam logic [3:0] MAX_B4   = 4'(MAX_BUTTONS);
    localparam logic [3:0] STABLE_4 = 4'(STABLE_COUNT);

    // configuration
    t_cfg w_cfg;

    ald_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (w_cfg)
    );

    // threshold table, no reset: the user must load entries before use; the block does not enforce it
    t_level r_thr [MAX_BUTTONS];
    t_level r_thr_rd;

    // sequencer and decoder state
    t_state     r_state,    n_state;
    t_level     r_prev_rd,  n_prev_rd;
    logic [3:0] r_cnt,      n_cnt;
    t_button    r_cur,      n_cur;
    t_button    r_prev_btn, n_prev_btn;
    t_time      r_edge,     n_edge;
    t_time      r_rpt,      n_rpt;
    logic       r_long,     n_long;
    t_time      r_last_smp, n_last_smp;
    logic [3:0] r_idx,      n_idx;

    // captured item
    t_level r_level;
    t_time  r_now;

    // output register
    logic       r_ov,     n_ov;
    t_button    r_obtn,   n_obtn;
    logic [1:0] r_oev,    n_oev;
    t_time      r_odur,   n_odur;
    logic       r_olast,  n_olast;

    // shared unit
    t_time u_a, u_b, u_lim;
    logic  u_abs;
    t_cmp  w_cmp;

    ald_diff_unit u_diff (
        .i_a   (u_a),
        .i_b   (u_b),
        .i_lim (u_lim),
        .i_abs (u_abs),
        .o_cmp (w_cmp)
    );

    logic       w_in_xfer;
    logic       w_out_free;
    logic       w_load;
    logic [3:0] w_eff_cnt;
    logic [3:0] w_cnt_inc;
    logic       w_hold_fire;

    assign w_in_xfer  = i_sample.valid && i_sample.ready;
    assign w_out_free = !r_ov || o_event.ready;
    assign w_load     = w_in_xfer && (i_sample.cmd == CMD_LOAD);
    // counts above the table depth act as the table depth
    assign w_eff_cnt  = (w_cfg.button_count > MAX_B4) ? MAX_B4 : w_cfg.button_count;
    assign w_cnt_inc  = r_cnt + 4'd1;

    always_comb begin
        n_state    = r_state;
        n_prev_rd  = r_prev_rd;
        n_cnt      = r_cnt;
        n_cur      = r_cur;
        n_prev_btn = r_prev_btn;
        n_edge     = r_edge;
        n_rpt      = r_rpt;
        n_long     = r_long;
        n_last_smp = r_last_smp;
        n_idx      = r_idx;

        n_ov    = r_ov && !o_event.ready;
        n_obtn  = r_obtn;
        n_oev   = r_oev;
        n_odur  = r_odur;
        n_olast = r_olast;

        // default unit use: elapsed time since the last edge
        u_a   = r_now;
        u_b   = r_edge;
        u_lim = '0;
        u_abs = 1'b0;

        w_hold_fire = 1'b0;
        i_sample.ready = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                i_sample.ready = 1'b1;
                if (i_sample.valid && (i_sample.cmd == CMD_SAMPLE)) begin
                    n_state = S_PERIOD;
                end
            end

            // samples arriving before the period is over are dropped
            S_PERIOD: begin
                u_b   = r_last_smp;
                u_lim = TIME_W'(w_cfg.sample_period_ms);
                n_state = w_cmp.lt ? S_IDLE : S_NOISE;
            end

            S_NOISE: begin
                u_a   = TIME_W'(r_level);
                u_b   = TIME_W'(r_prev_rd);
                u_lim = TIME_W'(w_cfg.noise_window);
                u_abs = 1'b1;
                if (w_cmp.le && (w_cnt_inc == STABLE_4)) begin
                    n_cnt   = '0;
                    n_state = S_ZERO;
                end else begin
                    n_cnt   = w_cmp.le ? w_cnt_inc : 4'd0;
                    n_state = S_CHANGE;
                end
            end

            S_ZERO: begin
                u_a   = TIME_W'(r_level);
                u_b   = TIME_W'(w_cfg.zero_level);
                u_lim = TIME_W'(w_cfg.match_window);
                u_abs = 1'b1;
                n_idx = '0;
                if (w_cmp.le) begin
                    n_cur   = '0;
                    n_state = S_CHANGE;
                end else begin
                    n_state = S_SCAN;
                end
            end

            // first matching threshold wins, no match keeps the button
            S_SCAN: begin
                u_a   = TIME_W'(r_level);
                u_b   = TIME_W'(r_thr_rd);
                u_lim = TIME_W'(w_cfg.match_window);
                u_abs = 1'b1;
                if (r_idx >= w_eff_cnt) begin
                    n_state = S_CHANGE;
                end else if (w_cmp.le) begin
                    n_cur   = r_idx + 4'd1;
                    n_state = S_CHANGE;
                end else begin
                    n_idx = r_idx + 4'd1;
                end
            end

            S_CHANGE: begin
                if (r_cur != r_prev_btn) begin
                    n_state = (r_prev_btn != '0) ? S_REL : S_PRS;
                end else begin
                    n_state = (r_cur != '0) ? S_HOLD : S_FIN;
                end
            end

            S_REL: begin
                if (w_out_free) begin
                    n_ov    = 1'b1;
                    n_obtn  = r_prev_btn;
                    n_oev   = EV_RELEASED;
                    n_odur  = w_cmp.diff;
                    n_olast = (r_cur == '0);
                    n_edge  = r_now;
                    n_state = (r_cur != '0) ? S_PRS : S_FIN;
                end
            end

            S_PRS: begin
                if (w_out_free) begin
                    n_ov    = 1'b1;
                    n_obtn  = r_cur;
                    n_oev   = EV_PRESSED;
                    n_odur  = w_cmp.diff;
                    n_olast = 1'b1;
                    n_edge  = r_now;
                    n_rpt   = r_now;
                    n_long  = 1'b0;
                    n_state = S_FIN;
                end
            end

            // held time against long press limit, then against repeat period
            S_HOLD: begin
                u_b   = r_rpt;
                u_lim = r_long ? TIME_W'(w_cfg.repeat_ms) : TIME_W'(w_cfg.long_press_ms);
                w_hold_fire = (u_lim != '0) && !w_cmp.le;
                n_state = w_hold_fire ? S_HEV : S_FIN;
            end

            S_HEV: begin
                if (w_out_free) begin
                    n_ov    = 1'b1;
                    n_obtn  = r_cur;
                    n_oev   = r_long ? EV_TICK : EV_LONG;
                    n_odur  = w_cmp.diff;
                    n_olast = 1'b1;
                    n_rpt   = r_now;
                    n_long  = 1'b1;
                    n_state = S_FIN;
                end
            end

            S_FIN: begin
                n_prev_btn = r_cur;
                n_prev_rd  = r_level;
                n_last_smp = r_now;
                n_state    = S_IDLE;
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_prev_rd  <= '0;
            r_cnt      <= '0;
            r_cur      <= '0;
            r_prev_btn <= '0;
            r_edge     <= '0;
            r_rpt      <= '0;
            r_long     <= 1'b0;
            r_last_smp <= '0;
            r_idx      <= '0;
            r_ov       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_prev_rd  <= n_prev_rd;
            r_cnt      <= n_cnt;
            r_cur      <= n_cur;
            r_prev_btn <= n_prev_btn;
            r_edge     <= n_edge;
            r_rpt      <= n_rpt;
            r_long     <= n_long;
            r_last_smp <= n_last_smp;
            r_idx      <= n_idx;
            r_ov       <= n_ov;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_level <= i_sample.level;
            r_now   <= i_sample.now_ms;
        end
        r_obtn  <= n_obtn;
        r_oev   <= n_oev;
        r_odur  <= n_odur;
        r_olast <= n_olast;
    end

    // threshold loads, slots past the table depth are dropped
    always_ff @(posedge i_clk) begin
        if (w_load && ({1'b0, i_sample.slot} < MAX_B4)) begin
            r_thr[IDX_W'(i_sample.slot)] <= i_sample.level;
        end
    end

    // registered table read, address follows the walk index
    always_ff @(posedge i_clk) begin
        r_thr_rd <= r_thr[n_idx[IDX_W-1:0]];
    end

    assign o_event.valid       = r_ov;
    assign o_event.button      = r_obtn;
    assign o_event.event_res   = r_oev;
    assign o_event.duration_ms = r_odur;
    assign o_event.last        = r_olast;

`ifndef NO_ASSERTIONS
    // an event is only produced by one of the emit steps
    a_emit_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> ($past(r_state) == S_REL || $past(r_state) == S_PRS
                         || $past(r_state) == S_HEV))
        else $error("event produced outside an emit step");

    // the stability counter restarts on reaching the stable count
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < STABLE_4)
        else $error("stability counter reached stable count");

    // the decoded button never points past the table
    a_cur_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur <= MAX_B4)
        else $error("current button beyond table depth");

    // the table walk stops at the effective entry count
    a_scan_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= w_eff_cnt))
        else $error("table walk past entry count");

    // a press event always closes the item and restarts the long press timer
    a_press_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PRS && w_out_free) |=> (r_olast && !r_long && r_rpt == r_now))
        else $error("press event not last or timer not restarted");
`endif
endmodule

// ----- tb/tb_ladder_pkg.sv -----
// ----------------------------------------------------------------------------
// tb_ladder_pkg
// event predictor and scoreboard for the analog ladder button decoder
// ----------------------------------------------------------------------------
package tb_ladder_pkg;
    import ald_pkg::*;

    localparam int KEYS     = 8;
    localparam int STABLE_N = 3;
    localparam int SHOWN    = 10;

    typedef struct packed {
        t_button button;
        t_event  ev;
        t_time   dur;
        logic    last;
    } t_key_event;

    class keypad_scoreboard;
        t_cfg        cfg;
        t_level      thr [KEYS];
        t_level      prev_lvl;
        logic [3:0]  stable;
        t_button     cur_key;
        t_button     prev_key;
        t_time       edge_t;
        t_time       rep_t;
        t_time       last_t;
        bit          long_done;
        t_key_event  due_events [$];
        int unsigned errors;

        function new();
            cfg       = '0;
            foreach (thr[i]) thr[i] = '0;
            prev_lvl  = '0;
            stable    = '0;
            cur_key   = '0;
            prev_key  = '0;
            edge_t    = '0;
            rep_t     = '0;
            last_t    = '0;
            long_done = 1'b0;
            errors    = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DAT_W-1:0] v);
            case (idx)
                REG_ZERO_LEVEL:    cfg.zero_level       = v[LEVEL_W-1:0];
                REG_BUTTON_COUNT:  cfg.button_count     = v[3:0];
                REG_MATCH_WINDOW:  cfg.match_window     = v[WIN_W-1:0];
                REG_NOISE_WINDOW:  cfg.noise_window     = v[WIN_W-1:0];
                REG_LONG_PRESS_MS: cfg.long_press_ms    = v[MS_W-1:0];
                REG_REPEAT_MS:     cfg.repeat_ms        = v[MS_W-1:0];
                REG_SAMPLE_PERIOD: cfg.sample_period_ms = v[MS_W-1:0];
                default: ;
            endcase
        endfunction

        function bit close_to(t_level a, t_level b, t_win w);
            t_level d;
            d = (a >= b) ? a - b : b - a;
            return d <= w;
        endfunction

        function int unsigned outstanding();
            return due_events.size();
        endfunction

        // one accepted input item: update the decoder state, queue its events
        function void take_item(logic cmd, t_level lvl, t_slot slot, t_time now);
            t_key_event fresh [$];
            int         keys;
            bit         hit;
            t_time      held;
            if (cmd == CMD_LOAD) begin
                if (int'(slot) < KEYS) thr[slot] = lvl;
                return;
            end
            if ((now - last_t) < t_time'(cfg.sample_period_ms)) return;

            if (close_to(lvl, prev_lvl, cfg.noise_window)) stable = stable + 4'd1;
            else stable = '0;

            if (stable == STABLE_N) begin
                if (close_to(lvl, cfg.zero_level, cfg.match_window)) begin
                    cur_key = '0;
                end else begin
                    keys = (cfg.button_count > KEYS) ? KEYS : int'(cfg.button_count);
                    hit  = 1'b0;
                    for (int i = 0; i < keys; i++) begin
                        if (!hit && close_to(lvl, thr[i], cfg.match_window)) begin
                            cur_key = t_button'(i + 1);
                            hit     = 1'b1;
                        end
                    end
                end
                stable = '0;
            end

            if (cur_key != prev_key) begin
                if (prev_key != '0) begin
                    fresh.push_back('{prev_key, EV_RELEASED, now - edge_t, 1'b0});
                    edge_t = now;
                end
                if (cur_key != '0) begin
                    fresh.push_back('{cur_key, EV_PRESSED, now - edge_t, 1'b0});
                    edge_t    = now;
                    rep_t     = now;
                    long_done = 1'b0;
                end
                prev_key = cur_key;
            end

            if (cur_key != '0) begin
                held = now - rep_t;
                if (!long_done && cfg.long_press_ms != '0 &&
                    held > t_time'(cfg.long_press_ms)) begin
                    fresh.push_back('{cur_key, EV_LONG, now - edge_t, 1'b0});
                    rep_t     = now;
                    long_done = 1'b1;
                end else if (long_done && cfg.repeat_ms != '0 &&
                             held > t_time'(cfg.repeat_ms)) begin
                    fresh.push_back('{cur_key, EV_TICK, now - edge_t, 1'b0});
                    rep_t = now;
                end
            end

            prev_lvl = lvl;
            last_t   = now;

            if (fresh.size() != 0) begin
                fresh[fresh.size() - 1].last = 1'b1;
                foreach (fresh[i]) due_events.push_back(fresh[i]);
            end
        endfunction

        // one accepted event: compare with the oldest queued one
        function void check_event(t_button b, logic [1:0] e, t_time d, logic l);
            t_key_event want;
            if (due_events.size() == 0) begin
                errors++;
                if (errors <= SHOWN)
                    $display("unexpected event: button %0d event %0d duration %0d last %0b",
                             b, e, d, l);
                return;
            end
            want = due_events.pop_front();
            if (want.button !== b || want.ev !== e || want.dur !== d || want.last !== l) begin
                errors++;
                if (errors <= SHOWN)
                    $display({"event mismatch: exp button %0d %s dur %0d last %0b, ",
                              "got button %0d event %0d dur %0d last %0b"},
                             want.button, want.ev.name(), want.dur, want.last, b, e, d, l);
            end
        endfunction
    endclass

endpackage

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the analog ladder button decoder
// ----------------------------------------------------------------------------
// Threshold loads and ADC samples are sent through the input channel with
// random gaps; every accepted item goes to a scoreboard that tracks the
// debounce, matching and hold timers and queues the events it expects. Each
// accepted event is compared field by field. A directed opening covers the
// level extremes, early samples, a stable reading with no match, a button
// change with release and press from one sample, long press, repeat tick and
// time wrap. Random phases then run press, hold, slide and release gestures
// mixed with noise under several register settings, extremes included.
// ----------------------------------------------------------------------------
module tb_top;
    import ald_pkg::*;
    import tb_ladder_pkg::*;

    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 5;
    localparam int CYCLE_LIMIT     = 2000000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int PRESSURE_CYCLES = 400;
    localparam int LEVEL_MAX       = 1023;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_DAT_W-1:0] cfg_wdata;

    ald_in_if  smp ();
    ald_out_if evq ();

    analog_ladder_button_decoder uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_sample    (smp),
        .o_event     (evq)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    keypad_scoreboard book;

    int unsigned cycles     = 0;
    bit          calm       = 1'b0;   // no idling on either side while set
    int          hold_off   = 0;      // long receiver stall, in cycles
    int          ready_wait = 0;

    // stimulus view of the current setting
    t_time  now_t;
    t_level ladder [KEYS];
    int     zl_m, keys_m, mw_m, nw_m, lp_m, rp_m, sp_m;
    int     spread;
    int     sent;

    // gap lengths: mostly short, some medium, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // receiver: random stalls, plus the long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            evq.ready <= 1'b0;
            hold_off--;
        end else if (ready_wait > 0) begin
            evq.ready <= 1'b0;
            ready_wait--;
        end else if (!calm && $urandom_range(0, 99) < 30) begin
            evq.ready <= 1'b0;
            ready_wait = pick_gap() - 1;
        end else begin
            evq.ready <= 1'b1;
        end
    end

    // event monitor: pre-edge values, so the transfer is the one the block saw
    always @(posedge i_clk) begin
        if (i_rst_n && evq.valid === 1'b1 && evq.ready === 1'b1)
            book.check_event(evq.button, evq.event_res, evq.duration_ms, evq.last);
    end

    // one input transfer; valid stays high across back-to-back items
    task automatic send_item(logic cmd, t_level lvl, t_slot slot, t_time stamp);
        int gap;
        gap = (calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
        if (gap > 0) begin
            smp.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        smp.valid  <= 1'b1;
        smp.cmd    <= cmd;
        smp.level  <= lvl;
        smp.slot   <= slot;
        smp.now_ms <= stamp;
        @(posedge i_clk);
        while (smp.ready !== 1'b1) @(posedge i_clk);
        book.take_item(cmd, lvl, slot, stamp);
    endtask

    task automatic sample_at(t_level lvl, t_time step);
        now_t = now_t + step;
        send_item(CMD_SAMPLE, lvl, t_slot'($urandom_range(0, 7)), now_t);
    endtask

    // early samples step less than the sample period past the previous sample, dropped if it was kept
    task automatic sample(t_level lvl, bit early);
        t_time step;
        if (early && sp_m > 0) begin
            step = t_time'($urandom_range(0, sp_m - 1));
        end else begin
            step = t_time'(sp_m) + t_time'($urandom_range(0, spread));
            sent++;
        end
        sample_at(lvl, step);
    endtask

    // reading near a target, consecutive steps stay inside the noise window
    function automatic t_level jitter(int target);
        int j;
        int v;
        j = ((nw_m < mw_m) ? nw_m : mw_m) / 2;
        v = target + int'($urandom_range(0, 2 * j)) - j;
        if (v < 0) v = 0;
        if (v > LEVEL_MAX) v = LEVEL_MAX;
        return t_level'(v);
    endfunction

    task automatic load_slot(t_slot s, t_level v);
        ladder[s] = v;
        sent++;
        send_item(CMD_LOAD, v, s, t_time'($urandom()));
    endtask

    task automatic load_ladder();
        int base;
        int step;
        int v;
        base = $urandom_range(0, 80);
        step = $urandom_range(60, 120);
        for (int i = 0; i < KEYS; i++) begin
            v = base + step * (i + 1);
            if (v > LEVEL_MAX || (i == KEYS - 1 && $urandom_range(0, 7) == 0)) v = LEVEL_MAX;
            if (i == 0 && $urandom_range(0, 9) == 0) v = 0;
            load_slot(t_slot'(i), t_level'(v));
        end
    endtask

    // press a button (or rest at zero level when none is in use), hold, maybe release
    task automatic key_gesture();
        int key;
        int target;
        key    = (keys_m == 0) ? 0 : $urandom_range(1, keys_m);
        target = (key == 0) ? zl_m : int'(ladder[key - 1]);
        repeat ($urandom_range(4, 6)) sample(jitter(target), 1'b0);
        repeat ($urandom_range(0, 10)) sample(jitter(target), $urandom_range(0, 9) == 0);
        if ($urandom_range(0, 1) == 1)
            repeat ($urandom_range(4, 5)) sample(jitter(zl_m), 1'b0);
    endtask

    // noise, early samples, table reloads and broken sequences
    task automatic junk_items();
        int key;
        case ($urandom_range(0, 3))
            0: repeat ($urandom_range(1, 4))
                   sample(t_level'($urandom_range(0, LEVEL_MAX)), $urandom_range(0, 1) == 1);
            1: load_slot(t_slot'($urandom_range(0, 7)), t_level'($urandom_range(0, LEVEL_MAX)));
            2: begin
                key = $urandom_range(0, KEYS - 1);
                repeat ($urandom_range(1, 2)) sample(jitter(ladder[key]), 1'b0);
                sample(t_level'($urandom_range(0, LEVEL_MAX)), 1'b0);
            end
            default: sample(t_level'($urandom_range(0, LEVEL_MAX)), 1'b1);
        endcase
    endtask

    // block idle: nothing queued, then let a sample with no event finish
    task automatic wait_idle();
        smp.valid <= 1'b0;
        while (book.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, int val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val[CFG_DAT_W-1:0];
        book.write_reg(idx, val[CFG_DAT_W-1:0]);
    endtask

    task automatic configure(int zl, int bc, int mw, int nw, int lp, int rp, int sp);
        wait_idle();
        write_reg(REG_ZERO_LEVEL, zl);
        write_reg(REG_BUTTON_COUNT, bc);
        write_reg(REG_MATCH_WINDOW, mw);
        write_reg(REG_NOISE_WINDOW, nw);
        write_reg(REG_LONG_PRESS_MS, lp);
        write_reg(REG_REPEAT_MS, rp);
        write_reg(REG_SAMPLE_PERIOD, sp);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        zl_m   = zl;
        keys_m = (bc > KEYS) ? KEYS : bc;
        mw_m   = mw;
        nw_m   = nw;
        lp_m   = lp;
        rp_m   = rp;
        sp_m   = sp;
        // time steps sized so holds reach the long press and tick periods
        spread = ((lp > rp) ? lp : rp) / 3 + 3;
    endtask

    task automatic run_phase(int quota, t_time base);
        now_t = base;
        sent  = 0;
        load_ladder();
        while (sent < quota) begin
            if ($urandom_range(0, 19) == 0) calm = !calm;
            if ($urandom_range(0, 99) < 75) key_gesture();
            else junk_items();
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        cfg_we     = 1'b0;
        cfg_idx    = '0;
        cfg_wdata  = '0;
        smp.valid  = 1'b0;
        smp.cmd    = CMD_SAMPLE;
        smp.level  = '0;
        smp.slot   = '0;
        smp.now_ms = '0;
        now_t      = '0;
        book       = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: full table first, so no unwritten entry is ever walked
        load_slot(t_slot'(0), t_level'(0));
        for (int i = 1; i < KEYS - 1; i++) load_slot(t_slot'(i), t_level'(150 * i));
        load_slot(t_slot'(KEYS - 1), t_level'(LEVEL_MAX));
        configure(0, KEYS, 10, 4, 30, 15, 3);

        // start just below the time wrap
        now_t = 32'hFFFF_FFE0;
        repeat (4) sample_at(t_level'(LEVEL_MAX), 4);     // press on the top threshold
        sample_at(t_level'(0), 1);                        // early sample, dropped
        repeat (3) sample_at(t_level'(LEVEL_MAX), 20);    // long press, then tick
        repeat (4) sample_at(t_level'(500), 5);           // stable but no match
        repeat (4) sample_at(t_level'(300), 5);           // release and press from one sample
        repeat (4) sample_at(t_level'(0), 5);             // back to zero level

        // typical setting, with the long receiver hold-off at the start
        configure(0, KEYS, 15, 6, 200, 50, 10);
        hold_off = PRESSURE_CYCLES;
        run_phase(350, t_time'($urandom()));

        // count above the table size, zero level at the top, long press off
        configure(LEVEL_MAX, 12, 30, 20, 0, 25, 0);
        run_phase(250, t_time'($urandom()));

        // zero level in mid ladder, ticks off, tight windows
        configure(512, 5, 8, 3, 40, 0, 1);
        run_phase(250, t_time'($urandom()));

        // all registers at their maximum
        configure(LEVEL_MAX, 15, LEVEL_MAX, LEVEL_MAX, 65535, 65535, 65535);
        run_phase(60, t_time'($urandom()));

        // all registers at their minimum
        configure(0, 0, 0, 0, 0, 0, 0);
        run_phase(60, t_time'($urandom()));

        // random moderate setting
        configure($urandom_range(0, LEVEL_MAX), $urandom_range(1, 15), $urandom_range(0, 40),
                  $urandom_range(0, 30), $urandom_range(1, 3000), $urandom_range(1, 1000),
                  $urandom_range(0, 200));
        run_phase(400, t_time'($urandom()));

        // shortest timers, exact levels, across the time wrap
        configure(0, KEYS, 0, 0, 1, 1, 2);
        run_phase(250, 32'hFFFF_FF00);

        // longest hold time with a coarse sample period
        configure($urandom_range(0, LEVEL_MAX), $urandom_range(1, KEYS), $urandom_range(4, 20),
                  $urandom_range(2, 12), 65535, $urandom_range(1, 65535), 1000);
        run_phase(300, t_time'($urandom()));

        wait_idle();
        if (book.errors == 0 && book.outstanding() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
